>>> sv/epcd_pkg.sv
// ----------------------------------------------------------------------------
// epcd_pkg
// Shared types, codes and constants for the event pixel count denoise block.
// ----------------------------------------------------------------------------
package epcd_pkg;

   // default store geometry
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   // field widths
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 9;
   localparam int DIM_W      = 10;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST    = 10'd346;
   localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST   = 10'd260;
   localparam logic [COUNT_W-1:0] KEEP_THRESHOLD_RST = 8'd2;

   // controller to datapath
   typedef struct packed {
      logic load_item;    // capture request and read its counter
      logic load_rsp;     // load the result register
      logic item_we;      // write back the incremented counter
      logic sweep_we;     // clear one counter of the sweep
      logic sweep_start;  // rewind the sweep address
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_clear;     // held command is a new-packet clear
      logic needs_write;  // held command is an in-frame count
      logic rsp_blocked;  // result register full and not taken
      logic sweep_last;   // sweep address at the last counter
   } dp_status_type;

endpackage

>>> sv/epcd_datapath.sv
// ----------------------------------------------------------------------------
// epcd_datapath
// Config registers, per-pixel count memory, sweep address, result register.
// ----------------------------------------------------------------------------
module epcd_datapath import epcd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_x, pixel_y, zero fill
   input  logic [CMD_W-1:0]      req_tuser,   // cmd
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // keep, pixel_count, zero fill
   output logic [RSP_USER_W-1:0] rsp_tuser,   // out_of_frame
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [DIM_W-1:0]   frame_width_ff;
   logic [DIM_W-1:0]   frame_height_ff;
   logic [COUNT_W-1:0] keep_threshold_ff;

   logic [COUNT_W-1:0] count_mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic               inside_in;
   logic [31:0]        addr_full;
   logic [AW-1:0]      item_addr;

   logic [CMD_W-1:0]   cmd_ff;
   logic               inside_ff;
   logic [AW-1:0]      addr_ff;
   logic [AW-1:0]      sweep_addr_ff;
   logic [AW-1:0]      sweep_addr_in;

   logic [COUNT_W-1:0] count_inc;
   logic               keep_res;
   logic [COUNT_W-1:0] count_res;
   logic               oof_res;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         keep_threshold_ff <= KEEP_THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_data;
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_data;
            CSR_KEEP_THRESHOLD: keep_threshold_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request decode
   assign pixel_x = req_tdata[COORD_W-1:0];
   assign pixel_y = req_tdata[2*COORD_W-1:COORD_W];

   assign inside_in = ({1'b0, pixel_x} < frame_width_ff) &&
                      ({1'b0, pixel_y} < frame_height_ff) &&
                      (32'(pixel_x) < 32'(MAX_WIDTH)) &&
                      (32'(pixel_y) < 32'(MAX_HEIGHT));

   assign addr_full = 32'(pixel_y) * 32'(MAX_WIDTH) + 32'(pixel_x);
   assign item_addr = addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff    <= req_tuser;
         inside_ff <= inside_in;
         addr_ff   <= item_addr;
      end
   end

   // count memory: one read, one write port
   assign count_inc = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         rd_data_ff <= count_mem[item_addr];
      end
      if (cmd.item_we) begin
         count_mem[addr_ff] <= count_inc;
      end else if (cmd.sweep_we) begin
         count_mem[sweep_addr_ff] <= '0;
      end
   end

   // sweep address
   always_comb begin
      sweep_addr_in = sweep_addr_ff;
      if (cmd.sweep_start) begin
         sweep_addr_in = '0;
      end else if (cmd.sweep_we) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
      end else begin
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   // result
   always_comb begin
      keep_res  = 1'b0;
      count_res = '0;
      oof_res   = 1'b0;
      case (cmd_ff)
         CMD_COUNT: begin
            if (inside_ff) begin
               count_res = count_inc;
            end else begin
               oof_res = 1'b1;
            end
         end
         CMD_QUERY: begin
            if (inside_ff) begin
               count_res = rd_data_ff;
               keep_res  = (rd_data_ff >= keep_threshold_ff);
            end else begin
               oof_res = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= RSP_DATA_W'({count_res, keep_res});
         rsp_user_ff <= oof_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign status.is_clear    = (cmd_ff == CMD_CLEAR);
   assign status.needs_write = (cmd_ff == CMD_COUNT) && inside_ff;
   assign status.rsp_blocked = rsp_valid_ff && !rsp_tready;
   assign status.sweep_last  = (sweep_addr_ff == LAST_ADDR);

   a_write_only_in_frame_count: assert property (@(posedge clock) disable iff (reset)
      cmd.item_we |-> (cmd_ff == CMD_COUNT) && inside_ff)
      else $error("counter written back for a command that counts nothing");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register loaded while still holding a result");

   a_one_write_source: assert property (@(posedge clock) disable iff (reset)
      !(cmd.item_we && cmd.sweep_we))
      else $error("item write and sweep write in the same cycle");

   a_clear_result_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && (cmd_ff == CMD_CLEAR) |=> (rsp_tdata == '0) && (rsp_tuser == '0))
      else $error("new-packet result not all zero");

endmodule

>>> sv/epcd_ctrl.sv
// ----------------------------------------------------------------------------
// epcd_ctrl
// Sequencer: accept, read-modify-write and result, counter clearing sweep.
// ----------------------------------------------------------------------------
module epcd_ctrl import epcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CALC  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0] st_ff;
   logic [1:0] st_in;

   always_comb begin
      st_in            = st_ff;
      req_tready       = 1'b0;
      cmd.load_item    = 1'b0;
      cmd.load_rsp     = 1'b0;
      cmd.item_we      = 1'b0;
      cmd.sweep_we     = 1'b0;
      cmd.sweep_start  = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               st_in         = ST_CALC;
            end
         end
         ST_CALC: begin
            // hold until the result register is free
            if (!status.rsp_blocked) begin
               cmd.load_rsp = 1'b1;
               cmd.item_we  = status.needs_write;
               if (status.is_clear) begin
                  cmd.sweep_start = 1'b1;
                  st_in           = ST_SWEEP;
               end else begin
                  st_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep_we = 1'b1;
            if (status.sweep_last) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // reset starts with a full clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_SWEEP;
      end else begin
         st_ff <= st_in;
      end
   end

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_SWEEP) |-> !req_tready)
      else $error("request taken during clearing sweep");

   a_accept_then_calc: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> (st_ff == ST_CALC))
      else $error("accepted item not followed by its update cycle");

   a_calc_leaves_when_free: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CALC) && !status.rsp_blocked |=> (st_ff != ST_CALC))
      else $error("update cycle repeated with a free result register");

endmodule

>>> sv/event_pixel_count_denoise.sv
// A request is taken in IDLE, which reads its counter; in CALC the result register
//   is loaded once it is free, and the result transfers while rsp_tready is high.
// Requests are taken only in IDLE, so a new item waits until the last one has done
//   its read-modify-write through the single read / single write port of the count memory.
// A new-packet command returns its result at once, then sweeps all
//   MAX_WIDTH * MAX_HEIGHT counters (262144 by default), one a cycle.
// Reset runs the same sweep; no request is taken until it ends.
// ----------------------------------------------------------------------------
// event_pixel_count_denoise
// Event-camera noise filter on a store of saturating per-pixel event counts.
// ----------------------------------------------------------------------------
module event_pixel_count_denoise import epcd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_x, pixel_y, zero fill
   input  logic [CMD_W-1:0]      req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // keep, pixel_count, zero fill
   output logic [RSP_USER_W-1:0] rsp_tuser,   // out_of_frame
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register writes are taken at any time
   assign csr_ready = 1'b1;

   epcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   epcd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> bench/denoise_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// denoise_checker
// Watches the request, result and register channels of the event pixel count
// denoise block, keeps its own copy of the per-pixel counters and frame
// registers, and compares every result transfer against the predicted one.
// ----------------------------------------------------------------------------
module denoise_checker import epcd_pkg::*; #(
   parameter int MAX_W = MAX_WIDTH_DEF,
   parameter int MAX_H = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_x, pixel_y, zero fill
   input  logic [CMD_W-1:0]      req_tuser,   // cmd
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // keep, pixel_count, zero fill
   input  logic [RSP_USER_W-1:0] rsp_tuser,   // out_of_frame
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic               keep;
      logic [COUNT_W-1:0] count;
      logic               out_of_frame;
   } pixel_verdict_type;

   logic [DIM_W-1:0]   frame_w;
   logic [DIM_W-1:0]   frame_h;
   logic [COUNT_W-1:0] keep_min;
   logic [COUNT_W-1:0] tally [int];   // missing entry is created as zero before use
   pixel_verdict_type  verdict_q [$];
   pixel_verdict_type  want;
   pixel_verdict_type  got;
   int                 issued;
   int                 retired;

   assign pending = issued - retired;

   function automatic pixel_verdict_type filter_event(input logic [CMD_W-1:0] cmd,
                                                      input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y);
      pixel_verdict_type v;
      int                key;
      logic              in_frame;
      v        = '0;
      key      = int'(y) * MAX_W + int'(x);
      in_frame = (x < frame_w) && (y < frame_h) && (int'(x) < MAX_W) && (int'(y) < MAX_H);
      case (cmd)
         CMD_CLEAR: begin
            tally.delete();
         end
         CMD_COUNT, CMD_QUERY: begin
            if (!in_frame) begin
               v.out_of_frame = 1'b1;
            end else begin
               if (!tally.exists(key)) tally[key] = '0;
               if (cmd == CMD_COUNT) begin
                  // saturate at full scale
                  if (tally[key] != '1) tally[key] = tally[key] + 1'b1;
               end else begin
                  v.keep = (tally[key] >= keep_min);
               end
               v.count = tally[key];
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         frame_w  = FRAME_WIDTH_RST;
         frame_h  = FRAME_HEIGHT_RST;
         keep_min = KEEP_THRESHOLD_RST;
         tally.delete();
         verdict_q.delete();
         issued     <= 0;
         retired    <= 0;
         fail_count <= 0;
      end else begin
         // retire results before taking new requests at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.keep         = rsp_tdata[0];
            got.count        = rsp_tdata[COUNT_W:1];
            got.out_of_frame = rsp_tuser[0];
            if (verdict_q.size() == 0) begin
               $display("%0t: result transfer with nothing pending: keep %0d count %0d oof %0d",
                        $time, got.keep, got.count, got.out_of_frame);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_q.pop_front();
               retired <= retired + 1;
               if (got != want) begin
                  $display("%0t: mismatch keep/count/oof expected %0d/%0d/%0d actual %0d/%0d/%0d",
                           $time, want.keep, want.count, want.out_of_frame,
                           got.keep, got.count, got.out_of_frame);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(filter_event(req_tuser, req_tdata[COORD_W-1:0],
                                             req_tdata[2*COORD_W-1:COORD_W]));
            issued <= issued + 1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:    frame_w  = csr_data[DIM_W-1:0];
               CSR_FRAME_HEIGHT:   frame_h  = csr_data[DIM_W-1:0];
               CSR_KEEP_THRESHOLD: keep_min = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives event count, query, new-packet and unused-code commands plus frame register
// writes into the denoise block under several idle and stall patterns; the
// checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import epcd_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 4_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // pixel_x, pixel_y, zero fill
   logic [CMD_W-1:0]      req_tuser = '0;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // keep, pixel_count, zero fill
   logic [RSP_USER_W-1:0] rsp_tuser;        // out_of_frame
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;

   event_pixel_count_denoise dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   denoise_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending);
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 12) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-2*COORD_W){1'b0}}, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every result is back, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_frame(input int w, input int h, input int thr);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_KEEP_THRESHOLD, thr);
      csr_valid <= 1'b0;
   endtask

   // count pass over a small hot spot, then replay the same events as queries
   task automatic run_packet(input int w, input int h, input int n_events);
      logic [COORD_W-1:0] xs [$];
      logic [COORD_W-1:0] ys [$];
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      int lim_x;
      int lim_y;
      int base_x;
      int base_y;
      lim_x  = (w < 1) ? 1 : ((w > 512) ? 512 : w);
      lim_y  = (h < 1) ? 1 : ((h > 512) ? 512 : h);
      base_x = $urandom_range(lim_x - 1);
      base_y = $urandom_range(lim_y - 1);
      for (int i = 0; i < n_events; i++) begin
         if ($urandom_range(9) == 0) begin
            x = COORD_W'($urandom_range(511));
            y = COORD_W'($urandom_range(511));
         end else begin
            x = COORD_W'((base_x + $urandom_range(3)) % lim_x);
            y = COORD_W'((base_y + $urandom_range(3)) % lim_y);
         end
         xs.push_back(x);
         ys.push_back(y);
         case ($urandom_range(24))
            0: send_event(CMD_UNUSED, COORD_W'($urandom_range(511)),
                          COORD_W'($urandom_range(511)));
            1: send_event(CMD_QUERY, x, y);   // query ahead of the count pass
            default: ;
         endcase
         send_event(CMD_COUNT, x, y);
      end
      for (int i = 0; i < n_events; i++) send_event(CMD_QUERY, xs[i], ys[i]);
   endtask

   initial begin
      int w;
      int h;
      int phase_start;
      logic [COORD_W-1:0] hx;
      logic [COORD_W-1:0] hy;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // wait out the clearing pass after reset
      while (!req_tready) @(posedge clock);

      // directed part, register reset values first
      send_event(CMD_COUNT, 9'd0, 9'd0);
      send_event(CMD_COUNT, 9'd0, 9'd0);
      send_event(CMD_QUERY, 9'd0, 9'd0);
      send_event(CMD_COUNT, 9'd345, 9'd259);
      send_event(CMD_QUERY, 9'd345, 9'd259);
      send_event(CMD_COUNT, 9'd346, 9'd0);
      send_event(CMD_QUERY, 9'd0, 9'd260);
      send_event(CMD_COUNT, 9'd511, 9'd511);
      send_event(CMD_QUERY, 9'd511, 9'd511);
      send_event(CMD_UNUSED, 9'd511, 9'd511);
      send_event(CMD_QUERY, 9'd1, 9'd1);
      send_event(CMD_CLEAR, 9'd511, 9'd511);
      send_event(CMD_QUERY, 9'd0, 9'd0);
      drain();
      // full frame, threshold zero keeps everything in frame
      program_frame(512, 512, 0);
      send_event(CMD_COUNT, 9'd511, 9'd511);
      send_event(CMD_QUERY, 9'd511, 9'd511);
      send_event(CMD_QUERY, 9'd10, 9'd10);
      drain();
      // width beyond the store, zero height
      program_frame(1023, 0, 255);
      send_event(CMD_COUNT, 9'd0, 9'd0);
      send_event(CMD_QUERY, 9'd511, 9'd0);
      drain();
      program_frame(1, 1, 1);
      send_event(CMD_COUNT, 9'd0, 9'd0);
      send_event(CMD_QUERY, 9'd0, 9'd0);
      send_event(CMD_COUNT, 9'd1, 9'd0);
      send_event(CMD_QUERY, 9'd0, 9'd1);
      drain();
      program_frame(0, 1023, 128);
      send_event(CMD_COUNT, 9'd0, 9'd0);
      send_event(CMD_QUERY, 9'd0, 9'd511);
      drain();

      // random part, one idle pattern per phase
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         case (p)
            0: begin w = 512; h = 512; end
            1: begin w = $urandom_range(1, 512); h = $urandom_range(1, 512); end
            2: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
            default: begin w = $urandom_range(100, 1023); h = $urandom_range(100, 1023); end
         endcase
         drain();
         phase_start = items_sent;
         if (p == 1) begin
            // drive one pixel past full scale
            program_frame(w, h, 255);
            hx = COORD_W'($urandom_range(w - 1));
            hy = COORD_W'($urandom_range(h - 1));
            repeat (260) send_event(CMD_COUNT, hx, hy);
            send_event(CMD_QUERY, hx, hy);
            drain();
            phase_start = items_sent;
         end
         program_frame(w, h, (p == 2) ? 1 : $urandom_range(1, 4));
         if (p == 2) begin
            send_event(CMD_CLEAR, COORD_W'($urandom_range(511)),
                       COORD_W'($urandom_range(511)));
         end
         while (items_sent - phase_start < 105) begin
            if ($urandom_range(9) < 3) drain();
            run_packet(w, h, $urandom_range(8, 24));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
